/* hdl/hpa_pkg.sv */
// Shared constants for the handle pool allocator: field widths, operation
// and status codes, and parameter defaults.
// No dependencies.
package hpa_pkg;

    // Field widths
    localparam int HANDLE_W = 8;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;

    // Stream data widths, rounded up to whole bytes
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Default pool size and the largest number of handles that can be released
    localparam int POOL_SIZE_DEF = 256;
    localparam int MAX_TRACKED   = 256;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TRY   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FREED      = 2'd3;

    // One result transaction
    typedef struct packed {
        logic                reused;
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
    } hpa_result_t;

endpackage

/* hdl/hpa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/handle_pool_allocator_top.sv */
// Handle pool allocator top level: request register, freed-handle FIFO,
// in-use bitmap, fresh counter and result register.
// Depends on hpa_pkg and hpa_ram.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------
//  s_      | in        | s_tvalid, s_tready | s_tdata: opcode, handle_in
//  m_      | out       | m_tvalid, m_tready | m_tdata: handle_out, status, reused
//
// One request is taken per cycle while the result register is empty or being taken;
// its result is loaded into the result register when the held request fires, then offered.
// The freed FIFO RAM is read at the edge that loads a request, so the head
// entry is ready when that request is processed; a same-edge write is forwarded.
// Synchronous reset clears pointers, counters and the in-use bitmap at once;
// no clearing pass is needed. A stalled result holds the request register.
module handle_pool_allocator_top #(
    parameter int POOL_SIZE = hpa_pkg::POOL_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hpa_pkg::S_DATA_W-1:0]  s_tdata,  // [1:0] opcode, [9:2] handle_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hpa_pkg::M_DATA_W-1:0]  m_tdata   // [7:0] handle_out, [9:8] status,
                                                    // [10] reused
);

    import hpa_pkg::*;

    // Only handles below MAX_TRACKED can ever be released, so the FIFO and
    // the bitmap need no more entries than that.
    localparam int QD = (POOL_SIZE < MAX_TRACKED) ? POOL_SIZE : MAX_TRACKED;
    localparam int PW = $clog2(QD);
    localparam int CW = $clog2(QD + 1);
    localparam int FW = $clog2(POOL_SIZE + 1);

    // Request register
    logic                in_valid_reg, in_valid_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [HANDLE_W-1:0] hin_reg;

    // Result register
    logic                out_valid_reg, out_valid_next;
    hpa_result_t         result_reg, result_next;

    // Allocator state
    logic [PW-1:0]       head_reg, head_next;
    logic [PW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [FW-1:0]       fresh_reg, fresh_next;
    logic [QD-1:0]       in_use_reg;

    // Forwarding of a FIFO write that lands on the address being read
    logic                byp_valid_reg, byp_valid_next;
    logic [HANDLE_W-1:0] byp_data_reg;

    logic                fire;
    logic                accept;
    logic                do_pop;
    logic                do_fresh;
    logic                do_push;
    logic                hin_ok;
    logic                fresh_left;
    logic [PW-1:0]       rd_addr;
    logic [HANDLE_W-1:0] ram_rdata;
    logic [HANDLE_W-1:0] head_data;
    logic [PW-1:0]       hin_idx;
    logic [PW-1:0]       pop_idx;
    logic [PW-1:0]       fresh_idx;

    // Handshake
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    assign head_data  = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign hin_ok     = (32'(hin_reg) < 32'(POOL_SIZE));
    assign hin_idx    = hin_reg[PW-1:0];
    assign pop_idx    = head_data[PW-1:0];
    assign fresh_idx  = fresh_reg[PW-1:0];
    assign fresh_left = (32'(fresh_reg) < 32'(POOL_SIZE));

    // Decode the held request and work out the result and next state
    always_comb begin
        do_pop      = 1'b0;
        do_fresh    = 1'b0;
        do_push     = 1'b0;
        result_next = '{reused: 1'b0, status: ST_OK, handle: '0};
        case (op_reg)
            OP_ALLOC: begin
                if (count_reg != '0) begin
                    do_pop      = fire;
                    result_next = '{reused: 1'b1, status: ST_OK, handle: head_data};
                end else if (fresh_left) begin
                    do_fresh    = fire;
                    result_next = '{reused: 1'b0, status: ST_OK,
                                    handle: HANDLE_W'(fresh_reg)};
                end else begin
                    result_next.status = ST_EXHAUSTED;
                end
            end
            OP_TRY: begin
                if (count_reg != '0) begin
                    do_pop      = fire;
                    result_next = '{reused: 1'b1, status: ST_OK, handle: head_data};
                end else begin
                    result_next.status = ST_NO_FREED;
                end
            end
            OP_FREE: begin
                if (hin_ok && in_use_reg[hin_idx]) begin
                    do_push = fire;
                end else begin
                    result_next.status = ST_NOT_ALLOCATED;
                end
            end
            default: begin
                result_next = '{reused: 1'b0, status: ST_OK, handle: '0};
            end
        endcase
    end

    // Advance pointers and counters
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        fresh_next = fresh_reg;
        if (do_pop) begin
            head_next  = (head_reg == PW'(QD - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (do_push) begin
            tail_next  = (tail_reg == PW'(QD - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (do_fresh) begin
            fresh_next = fresh_reg + 1'b1;
        end
    end

    // Read the head that the next request will see
    assign rd_addr        = fire ? head_next : head_reg;
    assign byp_valid_next = accept ? (do_push && (tail_reg == rd_addr)) : byp_valid_reg;

    // Result valid: set on a processed request, drop when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            in_use_reg    <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            byp_valid_reg <= byp_valid_next;
            if (do_pop) begin
                in_use_reg[pop_idx] <= 1'b1;
            end
            if (do_fresh && (32'(fresh_reg) < 32'(QD))) begin
                in_use_reg[fresh_idx] <= 1'b1;
            end
            if (do_push) begin
                in_use_reg[hin_idx] <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= s_tdata[OPCODE_W-1:0];
            hin_reg      <= s_tdata[OPCODE_W +: HANDLE_W];
            byp_data_reg <= hin_reg;
        end
        if (fire) begin
            result_reg <= result_next;
        end
    end

    // Freed-handle FIFO storage
    hpa_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (QD)
    ) u_free_queue (
        .clk   (aclk),
        .we    (do_push),
        .waddr (tail_reg),
        .wdata (hin_reg),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Outputs
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(result_reg);

`ifndef SYNTH
    // An empty FIFO has its read and write positions together
    a_empty_ptrs : assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("freed FIFO empty but head and tail differ");

    // The FIFO never holds more handles than it can track
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(QD))
        else $error("freed FIFO count beyond depth");

    // A reused grant always reports success
    a_reused_ok : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result_reg.reused) |-> (result_reg.status == ST_OK))
        else $error("reused grant with failing status");

    // The fresh counter only advances when the FIFO is empty
    a_fresh_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        (fresh_next != fresh_reg) |-> (count_reg == '0))
        else $error("fresh handle issued while freed handles wait");
`endif

endmodule
